// File: hdl/mgrt_pkg.sv
// ----------------------------------------------------------------------------
// mgrt_pkg
// Shared types and constants for the min gap and range tracker.
// ----------------------------------------------------------------------------
package mgrt_pkg;

    localparam int VALUE_W     = 32;
    localparam int CAP_W       = 11;
    localparam int COUNT_OUT_W = 11;
    localparam int GAP_W       = 33;
    localparam int SPAN_W      = 32;

    // flips the sign bit so unsigned compares follow signed order
    localparam logic [VALUE_W-1:0] SIGN_BIAS = 32'h8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take_in;   // input transfer this cycle
        logic cfg_we;    // capacity write
        logic rd_en;     // read next stored entry
        logic commit;    // store value, update count/min/max
        logic load_out;  // load output register
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;       // count has reached the effective capacity
        logic count_zero; // nothing stored yet
        logic scan_last;  // current read index is the last stored entry
        logic busy;       // distance pipeline still holds data
        logic out_free;   // output register can take a new result
    } t_dp_sts;

endpackage

// File: hdl/mgrt_ram.sv
// ----------------------------------------------------------------------------
// mgrt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mgrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/mgrt_ctrl.sv
// ----------------------------------------------------------------------------
// mgrt_ctrl
// Sequencer: accept, scan the store, drain, commit, hand over the result.
// ----------------------------------------------------------------------------
module mgrt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_cfg_valid,
    input  mgrt_pkg::t_dp_sts   i_sts,
    output mgrt_pkg::t_ctrl_cmd o_cmd,
    output logic                o_in_stall,
    output logic                o_cfg_ready
);

    mgrt_pkg::t_state r_state;
    mgrt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mgrt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        case (r_state)
            mgrt_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cfg_ready  = 1'b1;
                o_cmd.cfg_we = i_cfg_valid;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    if (i_sts.full) begin
                        n_state = mgrt_pkg::S_OUT;
                    end else if (i_sts.count_zero) begin
                        n_state = mgrt_pkg::S_COMMIT;
                    end else begin
                        n_state = mgrt_pkg::S_SCAN;
                    end
                end
            end
            mgrt_pkg::S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = mgrt_pkg::S_DRAIN;
                end
            end
            mgrt_pkg::S_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = mgrt_pkg::S_COMMIT;
                end
            end
            mgrt_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = mgrt_pkg::S_OUT;
            end
            mgrt_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mgrt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mgrt_pkg::S_IDLE;
            end
        endcase
    end

    // store must only be written once every pending distance has been folded in
    a_commit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mgrt_pkg::S_COMMIT) |-> !i_sts.busy)
        else $error("commit while distance pipeline busy");

    // a scan is never started on an empty store
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mgrt_pkg::S_SCAN) |-> !i_sts.count_zero)
        else $error("scan with empty store");

endmodule

// File: hdl/mgrt_dp.sv
// ----------------------------------------------------------------------------
// mgrt_dp
// Datapath: value store, distance pipeline, running min/max/gap, output reg.
// ----------------------------------------------------------------------------
module mgrt_dp #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mgrt_pkg::t_ctrl_cmd                    i_cmd,
    output mgrt_pkg::t_dp_sts                      o_sts,
    input  logic signed [mgrt_pkg::VALUE_W-1:0]    i_value,
    input  logic [mgrt_pkg::CAP_W-1:0]             i_cfg_data,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic                                   o_status,
    output logic [mgrt_pkg::COUNT_OUT_W-1:0]       o_stored_count,
    output logic                                   o_spans_valid,
    output logic [mgrt_pkg::SPAN_W-1:0]            o_shortest_span,
    output logic [mgrt_pkg::SPAN_W-1:0]            o_longest_span
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LW = (CW > mgrt_pkg::CAP_W) ? CW : mgrt_pkg::CAP_W;
    localparam int VW = mgrt_pkg::VALUE_W;

    // control registers
    logic [CW-1:0]                 r_count;
    logic [mgrt_pkg::GAP_W-1:0]    r_gap;
    logic [VW-1:0]                 r_max;
    logic [VW-1:0]                 r_min;
    logic [mgrt_pkg::CAP_W-1:0]    r_cap;
    logic                          r_rd_vld;
    logic                          r_d_vld;
    logic                          r_out_valid;

    // payload registers
    logic [VW-1:0]                 r_value;
    logic                          r_reject;
    logic [CW-1:0]                 r_idx;
    logic [VW-1:0]                 r_dist;
    logic                          r_out_status;
    logic [mgrt_pkg::COUNT_OUT_W-1:0] r_out_count;
    logic                          r_out_spans_valid;
    logic [mgrt_pkg::SPAN_W-1:0]   r_out_short;
    logic [mgrt_pkg::SPAN_W-1:0]   r_out_long;

    logic [VW-1:0]                 rd_data;
    logic [LW-1:0]                 limit;
    logic [LW-1:0]                 cap_ext;
    logic [LW-1:0]                 max_ext;
    logic [VW-1:0]                 new_b;
    logic [VW-1:0]                 old_b;
    logic [VW-1:0]                 n_dist;
    logic [CW-1:0]                 n_idx;
    logic                          gap_less;
    logic                          spans_ok;

    mgrt_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // effective capacity saturates at store depth
    assign cap_ext = LW'(r_cap);
    assign max_ext = LW'(MAX_ENTRIES);
    assign limit   = (cap_ext > max_ext) ? max_ext : cap_ext;

    assign n_idx = r_idx + CW'(1);

    assign new_b  = r_value ^ mgrt_pkg::SIGN_BIAS;
    assign old_b  = rd_data ^ mgrt_pkg::SIGN_BIAS;
    assign n_dist = (new_b > old_b) ? (new_b - old_b) : (old_b - new_b);

    assign gap_less = {1'b0, r_dist} < r_gap;
    assign spans_ok = r_count >= CW'(2);

    assign o_sts.full       = LW'(r_count) >= limit;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.scan_last  = (n_idx == r_count);
    assign o_sts.busy       = r_rd_vld | r_d_vld;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_gap       <= '1;
            r_max       <= '0;
            r_min       <= '0;
            r_cap       <= '0;
            r_rd_vld    <= 1'b0;
            r_d_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_rd_vld <= i_cmd.rd_en;
            r_d_vld  <= r_rd_vld;
            if (r_d_vld && gap_less) begin
                r_gap <= {1'b0, r_dist};
            end
            if (i_cmd.commit) begin
                r_count <= r_count + CW'(1);
                if (r_count == '0) begin
                    r_max <= r_value;
                    r_min <= r_value;
                end else begin
                    if (new_b > (r_max ^ mgrt_pkg::SIGN_BIAS)) begin
                        r_max <= r_value;
                    end
                    if (new_b < (r_min ^ mgrt_pkg::SIGN_BIAS)) begin
                        r_min <= r_value;
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_value  <= i_value;
            r_reject <= o_sts.full;
            r_idx    <= '0;
        end else if (i_cmd.rd_en) begin
            r_idx <= n_idx;
        end
        if (r_rd_vld) begin
            r_dist <= n_dist;
        end
        if (i_cmd.load_out) begin
            r_out_status      <= r_reject;
            r_out_count       <= mgrt_pkg::COUNT_OUT_W'(r_count);
            r_out_spans_valid <= spans_ok;
            r_out_short       <= spans_ok ? r_gap[mgrt_pkg::SPAN_W-1:0] : '0;
            r_out_long        <= spans_ok ? ((r_max ^ mgrt_pkg::SIGN_BIAS) -
                                             (r_min ^ mgrt_pkg::SIGN_BIAS)) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_stored_count  = r_out_count;
    assign o_spans_valid   = r_out_spans_valid;
    assign o_shortest_span = r_out_short;
    assign o_longest_span  = r_out_long;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("stored count beyond store depth");

    a_no_commit_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !r_reject)
        else $error("rejected value written to store");

    a_gap_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_gap <= $past(r_gap))
        else $error("smallest gap grew");

endmodule

// File: hdl/min_gap_and_range_tracker.sv
// ----------------------------------------------------------------------------
// min_gap_and_range_tracker
// Stores signed values up to a programmable capacity and reports the
// smallest gap between any two stored values and the overall range.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_value
//  out     | output    | o_out_valid / i_out_stall | status, count, spans
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (capacity)
//
//  Accepted value: a scan with one store read per cycle over all held entries,
//  then pipeline drain, commit and output load; an empty store skips scan
//  and drain. A rejected value goes straight to the output load.
//  The single store read port sets the scan length.
//  Reset (i_rst_n low, synchronous) empties the store; no clearing pass.
//  A held result blocks only the final output load; the next item may be
//  accepted while it waits.
// ----------------------------------------------------------------------------
module min_gap_and_range_tracker #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [mgrt_pkg::VALUE_W-1:0] i_value,
    // result item
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_status,
    output logic [mgrt_pkg::COUNT_OUT_W-1:0]    o_stored_count,
    output logic                                o_spans_valid,
    output logic [mgrt_pkg::SPAN_W-1:0]         o_shortest_span,
    output logic [mgrt_pkg::SPAN_W-1:0]         o_longest_span,
    // capacity register write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mgrt_pkg::CAP_W-1:0]          i_cfg_data
);

    // command and status between sequencer and datapath
    mgrt_pkg::t_ctrl_cmd cmd;
    mgrt_pkg::t_dp_sts   sts;

    // sequencer: one item in flight, walks it through scan/drain/commit/out
    mgrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    // datapath: store RAM, |new - old| pipeline, running min/max/gap,
    // and the output register that decouples the result from the next item
    mgrt_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_value         (i_value),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_stored_count  (o_stored_count),
        .o_spans_valid   (o_spans_valid),
        .o_shortest_span (o_shortest_span),
        .o_longest_span  (o_longest_span)
    );

endmodule

// File: test/min_gap_and_range_tracker_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_gap_and_range_tracker_checker
// Watches the value, result and capacity channels, keeps its own copy of
// the stored set and compares each result transfer with the predicted one.
// ----------------------------------------------------------------------------
module min_gap_and_range_tracker_checker #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [mgrt_pkg::VALUE_W-1:0]     i_value,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_status,
    input  logic [mgrt_pkg::COUNT_OUT_W-1:0] i_stored_count,
    input  logic                             i_spans_valid,
    input  logic [mgrt_pkg::SPAN_W-1:0]      i_shortest_span,
    input  logic [mgrt_pkg::SPAN_W-1:0]      i_longest_span,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [mgrt_pkg::CAP_W-1:0]       i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_held,
    output int                               o_rejected
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic                             status;
        logic [mgrt_pkg::COUNT_OUT_W-1:0] stored_count;
        logic                             spans_valid;
        logic [mgrt_pkg::SPAN_W-1:0]      shortest_span;
        logic [mgrt_pkg::SPAN_W-1:0]      longest_span;
    } t_span_report;

    logic [mgrt_pkg::VALUE_W-1:0] held_values [MAX_ENTRIES];
    int unsigned                  held_count;
    logic [mgrt_pkg::GAP_W-1:0]   min_gap;
    logic [mgrt_pkg::VALUE_W-1:0] top_value;
    logic [mgrt_pkg::VALUE_W-1:0] bottom_value;
    logic [mgrt_pkg::CAP_W-1:0]   capacity;
    t_span_report                 reports_due [$];
    int                           fail_count;
    int                           rejected_count;
    int                           result_index;

    // sign flip so that unsigned compares follow signed order
    function automatic logic [mgrt_pkg::VALUE_W-1:0] order_key(
        logic [mgrt_pkg::VALUE_W-1:0] raw);
        return raw ^ mgrt_pkg::SIGN_BIAS;
    endfunction

    task automatic predict_report(input logic [mgrt_pkg::VALUE_W-1:0] raw,
                                  output t_span_report rpt);
        logic [mgrt_pkg::VALUE_W-1:0] key;
        logic [mgrt_pkg::VALUE_W-1:0] other;
        logic [mgrt_pkg::VALUE_W-1:0] delta;
        int unsigned                  limit;
        key   = order_key(raw);
        limit = (int'(capacity) > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
        rpt   = '0;
        if (held_count >= limit) begin
            rpt.status = 1'b1;
            rejected_count++;
        end else begin
            for (int i = 0; i < held_count; i++) begin
                other = order_key(held_values[i]);
                delta = (key > other) ? key - other : other - key;
                if ({1'b0, delta} < min_gap)
                    min_gap = {1'b0, delta};
            end
            if (held_count == 0) begin
                top_value    = raw;
                bottom_value = raw;
            end else begin
                if (key > order_key(top_value))
                    top_value = raw;
                if (key < order_key(bottom_value))
                    bottom_value = raw;
            end
            held_values[held_count] = raw;
            held_count++;
        end
        rpt.stored_count = held_count[mgrt_pkg::COUNT_OUT_W-1:0];
        if (held_count >= 2) begin
            rpt.spans_valid   = 1'b1;
            rpt.shortest_span = min_gap[mgrt_pkg::SPAN_W-1:0];
            rpt.longest_span  = order_key(top_value) - order_key(bottom_value);
        end
    endtask

    task automatic report_failure(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] FAIL: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string field,
                               input logic [mgrt_pkg::SPAN_W-1:0] want,
                               input logic [mgrt_pkg::SPAN_W-1:0] got);
        if (want !== got)
            report_failure($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                     result_index, field, want, got));
    endtask

    initial begin
        fail_count     = 0;
        rejected_count = 0;
        result_index   = 0;
        held_count     = 0;
        capacity       = '0;
        min_gap        = '1;
    end

    always @(posedge i_clk) begin
        t_span_report want;
        t_span_report rpt;
        if (!i_rst_n) begin
            held_count   = 0;
            min_gap      = '1;
            top_value    = '0;
            bottom_value = '0;
            capacity     = '0;
            reports_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                capacity = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (reports_due.size() == 0) begin
                    report_failure($sformatf("result %0d arrived with none outstanding",
                                             result_index));
                end else begin
                    want = reports_due.pop_front();
                    check_field("status", mgrt_pkg::SPAN_W'(want.status),
                                mgrt_pkg::SPAN_W'(i_status));
                    check_field("stored_count", mgrt_pkg::SPAN_W'(want.stored_count),
                                mgrt_pkg::SPAN_W'(i_stored_count));
                    check_field("spans_valid", mgrt_pkg::SPAN_W'(want.spans_valid),
                                mgrt_pkg::SPAN_W'(i_spans_valid));
                    check_field("shortest_span", want.shortest_span, i_shortest_span);
                    check_field("longest_span", want.longest_span, i_longest_span);
                end
                result_index++;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_report(i_value, rpt);
                reports_due.insert(reports_due.size(), rpt);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= reports_due.size();
        o_held       <= held_count;
        o_rejected   <= rejected_count;
    end

endmodule

// File: test/min_gap_and_range_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_gap_and_range_tracker_test
// Drives values and capacity settings into the tracker, with random idle
// gaps on the value side and random stalls on the result side. A checker
// beside the block predicts every result and counts mismatches; this module
// only makes stimulus and prints the verdict.
// ----------------------------------------------------------------------------
module min_gap_and_range_tracker_test;

    localparam int MAX_ENTRIES   = 1024;
    localparam int RANDOM_ITEMS  = 560;
    // worst case is a scan over the full store per stored value plus stalls, taken several times
    localparam int LIMIT_CYCLES  = 3_000_000;
    // longest scan the block can run, plus margin, for stray results at the end
    localparam int DRAIN_CYCLES  = MAX_ENTRIES + 64;
    // short settle before a capacity write
    localparam int SETTLE_CYCLES = 8;
    localparam logic [mgrt_pkg::CAP_W-1:0] CAP_MAX = '1;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [mgrt_pkg::VALUE_W-1:0]     value;
    logic                             out_valid;
    logic                             out_stall;
    logic                             status;
    logic [mgrt_pkg::COUNT_OUT_W-1:0] stored_count;
    logic                             spans_valid;
    logic [mgrt_pkg::SPAN_W-1:0]      shortest_span;
    logic [mgrt_pkg::SPAN_W-1:0]      longest_span;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [mgrt_pkg::CAP_W-1:0]       cfg_data;

    int                           fail_count;
    int                           pending;
    int                           held;
    int                           rejected;
    int                           cycles = 0;
    int                           sent_total = 0;
    int                           cap_writes = 0;
    int                           stall_left = 0;
    bit                           calm = 1'b0;  // no idling on either side while set
    logic [mgrt_pkg::VALUE_W-1:0] recent [$];   // recently sent values, reused for duplicates

    // clock: 10 ns period
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    min_gap_and_range_tracker #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_value        (value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_stored_count (stored_count),
        .o_spans_valid  (spans_valid),
        .o_shortest_span(shortest_span),
        .o_longest_span (longest_span),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    min_gap_and_range_tracker_checker #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_value        (value),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_stored_count (stored_count),
        .i_spans_valid  (spans_valid),
        .i_shortest_span(shortest_span),
        .i_longest_span (longest_span),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_held         (held),
        .o_rejected     (rejected)
    );

    // run limit: a hung handshake ends here
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure: mostly open, short stalls, now and then a long one
    always @(posedge clk) begin
        int pick;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (calm) begin
            out_stall <= 1'b0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 8);
            end else if (pick < 93) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    // idle cycles before the next value: mostly none or a few, rarely many
    function automatic int pick_idle();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 50)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // values cluster around a per-phase base so that small gaps and
    // duplicates show up, with full-range values and extremes mixed in
    function automatic logic [mgrt_pkg::VALUE_W-1:0] pick_value(
        logic [mgrt_pkg::VALUE_W-1:0] base);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return $urandom;
        if (pick < 65)
            return base + $urandom_range(0, 200) - 100;
        if (pick < 80 && recent.size() > 0)
            return recent[$urandom_range(0, recent.size() - 1)];
        if (pick < 90) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return base + $urandom_range(0, 3);
    endfunction

    // one value transfer; valid stays high across back-to-back transfers
    task automatic send_value(input logic [mgrt_pkg::VALUE_W-1:0] v);
        int idle;
        idle = pick_idle();
        if (idle > 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (in_stall);
        sent_total++;
        recent.insert(recent.size(), v);
        if (recent.size() > 64)
            void'(recent.pop_front());
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // capacity is only written while the block is idle
    task automatic write_capacity(input logic [mgrt_pkg::CAP_W-1:0] cap);
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_writes++;
        @(posedge clk);
    endtask

    initial begin
        int                           random_sent;
        int                           burst;
        int                           cap_pick;
        logic [mgrt_pkg::VALUE_W-1:0] base;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        value     <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // capacity still at its reset value of zero: everything is turned away
        send_value(32'h7FFF_FFFF);
        // room for one: a single stored value gives no spans
        write_capacity(11'd1);
        send_value(32'h8000_0000);
        send_value(32'h0000_0005);        // full now, spans still invalid
        // capacity above store depth; widest gap and range first
        write_capacity(CAP_MAX);
        send_value(32'h7FFF_FFFF);
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);        // gap of one across zero
        send_value(32'hFFFF_FFFF);        // duplicate, gap of zero
        send_value(32'h0000_0001);
        send_value(32'h4000_0000);
        send_value(32'hC000_0000);
        // capacity lowered below what is held: rejected, spans keep current store
        write_capacity(11'd3);
        send_value(32'h1234_5678);
        send_value(32'h8000_0001);
        write_capacity(11'd0);
        send_value(32'h0000_0002);
        // capacity exactly at the held count, then one slot more
        wait_quiet();
        write_capacity(held[mgrt_pkg::CAP_W-1:0]);
        send_value(32'hDEAD_BEEF);
        write_capacity(held[mgrt_pkg::CAP_W-1:0] + 11'd1);
        send_value(32'hDEAD_BEEF);
        send_value(32'h0000_0003);

        // --- random part: phases with one capacity setting each ---
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_quiet();
            case ($urandom_range(0, 19))
                0:       cap_pick = held;
                1:       cap_pick = $urandom_range(0, held);
                2:       cap_pick = CAP_MAX;
                3:       cap_pick = $urandom_range(0, CAP_MAX);
                default: cap_pick = held + $urandom_range(1, 60);
            endcase
            if (cap_pick > CAP_MAX)
                cap_pick = CAP_MAX;
            write_capacity(cap_pick[mgrt_pkg::CAP_W-1:0]);
            calm  = ($urandom_range(0, 3) == 0);
            base  = $urandom;
            burst = $urandom_range(8, 40);
            repeat (burst) send_value(pick_value(base));
            random_sent += burst;
        end
        calm = 1'b0;

        // let the last results out and watch for stray ones
        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d values over %0d capacity writes: %0d stored, %0d turned away.",
                 sent_total, cap_writes, held, rejected);
        if (pending != 0)
            $display("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
